/* hw/rtl/crccmb_pkg.sv */
// Shared types, constants and GF(2) operator helpers for the CRC-32 combine engine.
// No dependencies.
package crccmb_pkg;

    localparam int CRC_W           = 32;
    localparam int LENGTH_BITS_DEF = 32;
    localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB8_8320;

    // 32x32 GF(2) operator: element i is the image of bit i
    typedef logic [CRC_W-1:0][CRC_W-1:0] mat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;    // capture item, build one-zero-bit operator
        logic square;  // operator <= operator^2
        logic step;    // conditional apply, square, shift length
        logic emit;    // write result register
    } cmd_t;

    typedef struct packed {
        logic len_in_zero;  // incoming length (used bits) is zero
        logic len_last;     // no set length bits remain after this step
        logic out_free;     // result register can take a new item
    } sts_t;

    function automatic logic [CRC_W-1:0] op_apply(input mat_t m, input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < CRC_W; i++) begin
            if (v[i]) begin
                sum = sum ^ m[i];
            end
        end
        return sum;
    endfunction

    function automatic mat_t op_square(input mat_t m);
        mat_t r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = op_apply(m, m[i]);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/crc32_combine_engine_core.sv */
// Sequence: a zero length goes from accept straight to the result write; otherwise
// three setup squarings, then one length step per bit up to the highest set length
// bit (at most 32), then the result write, which waits for a free result register.
// Items are accepted only while idle; one 32x32 GF(2) squaring serves every step.
// A finished result waits in the output register while the next item is accepted.
// Reset (aresetn, synchronous, active low) empties the result register, idles the
// sequencer and restores poly to 0xEDB88320.
module crc32_combine_engine_core #(
    parameter int LENGTH_BITS = crccmb_pkg::LENGTH_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [crccmb_pkg::CRC_W-1:0]  cfg_poly,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [crccmb_pkg::CRC_W-1:0]  s_crc_a,
    input  logic [crccmb_pkg::CRC_W-1:0]  s_crc_b,
    input  logic [crccmb_pkg::CRC_W-1:0]  s_length_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [crccmb_pkg::CRC_W-1:0]  m_crc_combined
);

    crccmb_pkg::cmd_t cmd;
    crccmb_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    crccmb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    crccmb_dp #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_poly       (cfg_poly),
        .s_crc_a        (s_crc_a),
        .s_crc_b        (s_crc_b),
        .s_length_b     (s_length_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crc_combined (m_crc_combined),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

/* hw/rtl/crccmb_ctrl.sv */
// Sequencer for the CRC-32 combine engine: setup squarings, length walk, result hand-off.
// Depends on crccmb_pkg.
module crccmb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  crccmb_pkg::sts_t   sts,
    output crccmb_pkg::cmd_t   cmd
);

    crccmb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crccmb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crccmb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sts.len_in_zero ? crccmb_pkg::ST_DONE : crccmb_pkg::ST_SQ0;
                end
            end
            crccmb_pkg::ST_SQ0: state_next = crccmb_pkg::ST_SQ1;
            crccmb_pkg::ST_SQ1: state_next = crccmb_pkg::ST_SQ2;
            crccmb_pkg::ST_SQ2: state_next = crccmb_pkg::ST_STEP;
            crccmb_pkg::ST_STEP: begin
                if (sts.len_last) begin
                    state_next = crccmb_pkg::ST_DONE;
                end
            end
            crccmb_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    state_next = crccmb_pkg::ST_IDLE;
                end
            end
            default: state_next = crccmb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            crccmb_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            crccmb_pkg::ST_SQ0,
            crccmb_pkg::ST_SQ1,
            crccmb_pkg::ST_SQ2: cmd.square = 1'b1;
            crccmb_pkg::ST_STEP: cmd.step = 1'b1;
            crccmb_pkg::ST_DONE: cmd.emit = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/crccmb_dp.sv */
// Datapath for the CRC-32 combine engine: poly register, operator register, CRC
// accumulator, length shifter and result register. Depends on crccmb_pkg.
module crccmb_dp #(
    parameter int LENGTH_BITS = crccmb_pkg::LENGTH_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [crccmb_pkg::CRC_W-1:0]  cfg_poly,
    input  logic [crccmb_pkg::CRC_W-1:0]  s_crc_a,
    input  logic [crccmb_pkg::CRC_W-1:0]  s_crc_b,
    input  logic [crccmb_pkg::CRC_W-1:0]  s_length_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [crccmb_pkg::CRC_W-1:0]  m_crc_combined,
    input  crccmb_pkg::cmd_t              cmd,
    output crccmb_pkg::sts_t              sts
);

    localparam int LEN_W = (LENGTH_BITS < crccmb_pkg::CRC_W) ? LENGTH_BITS : crccmb_pkg::CRC_W;

    logic [crccmb_pkg::CRC_W-1:0] poly_reg;
    crccmb_pkg::mat_t             mat_reg, mat_next, mat_sq, mat_init;
    logic [crccmb_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic [crccmb_pkg::CRC_W-1:0] crcb_reg;
    logic [LEN_W-1:0]             len_reg, len_next;
    logic                         zero_reg;
    logic [crccmb_pkg::CRC_W-1:0] res_reg;
    logic                         m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= crccmb_pkg::POLY_RESET;
        end else if (cfg_valid) begin
            poly_reg <= cfg_poly;
        end
    end

    // operator for one zero bit: column 0 is the poly, the rest a shift
    always_comb begin
        mat_init[0] = poly_reg;
        for (int i = 1; i < crccmb_pkg::CRC_W; i++) begin
            mat_init[i] = crccmb_pkg::CRC_W'(1) << (i - 1);
        end
    end

    assign mat_sq = crccmb_pkg::op_square(mat_reg);

    always_comb begin
        mat_next = mat_reg;
        crc_next = crc_reg;
        len_next = len_reg;
        if (cmd.load) begin
            mat_next = mat_init;
            crc_next = s_crc_a;
            len_next = s_length_b[LEN_W-1:0];
        end else if (cmd.square) begin
            mat_next = mat_sq;
        end else if (cmd.step) begin
            // mat_reg already holds the operator for this length bit
            mat_next = mat_sq;
            if (len_reg[0]) begin
                crc_next = crccmb_pkg::op_apply(mat_reg, crc_reg);
            end
            len_next = len_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        mat_reg <= mat_next;
        crc_reg <= crc_next;
        len_reg <= len_next;
        if (cmd.load) begin
            crcb_reg <= s_crc_b;
            zero_reg <= (s_length_b[LEN_W-1:0] == '0);
        end
        if (cmd.emit) begin
            res_reg <= zero_reg ? crc_reg : (crc_reg ^ crcb_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_crc_combined  = res_reg;
    assign sts.len_in_zero = (s_length_b[LEN_W-1:0] == '0);
    assign sts.len_last    = ((len_reg >> 1) == '0);
    assign sts.out_free    = !m_valid_reg || m_ready;

    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (len_reg != '0))
        else $error("length walk running on an exhausted length");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_load_poly: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (mat_reg[0] == $past(poly_reg)))
        else $error("one-bit operator not built from poly");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("emitted item not presented");

endmodule
